// ----- src/scanout_slot_cache_round_robin_core_macros.svh -----
// Assertion macros shared by the scanout slot cache RTL.
`ifndef SCANOUT_SLOT_CACHE_ROUND_ROBIN_CORE_MACROS_SVH
`define SCANOUT_SLOT_CACHE_ROUND_ROBIN_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSCRR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sscrr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSCRR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sscrr: next-cycle check failed");

`endif

// ----- src/sscrr_pkg.sv -----
// Shared types, constants and codes of the scanout slot cache.
package sscrr_pkg;

    localparam int DEF_NUM_SLOTS  = 4;
    localparam int DEF_SLOT_PAGES = 2048;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int HANDLE_W = 32;
    localparam int PAGES_W  = 21;
    localparam int OFFSET_W = 32;
    localparam int SLOTNUM_W = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = OFFSET_W - PAGE_SHIFT;
    localparam int SLOT_PAGES_W = 17;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_BASE_ENTRY = 1'b0;

    localparam logic [STATUS_W-1:0] STAT_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BOUND   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_BIG = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_space;
    } ctrl_stat_t;

endpackage

// ----- src/sscrr_ctrl.sv -----
// Controller state machine that sequences one bind transaction at a time.
module sscrr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sscrr_pkg::ctrl_stat_t stat,
    output sscrr_pkg::ctrl_cmd_t  cmd
);
    import sscrr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: state_next = S_READ;
            S_READ:   state_next = S_EMIT;
            S_EMIT: begin
                if (stat.out_space) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_LOOKUP: cmd.lookup = 1'b1;
            S_READ:   cmd = '0;
            S_EMIT:   cmd.commit = stat.out_space;
            default:  cmd = '0;
        endcase
    end

endmodule

// ----- src/sscrr_datapath.sv -----
// Datapath: request capture, tag compare, slot choice, offset, slot tables, result register.
module sscrr_datapath #(
    parameter int NUM_SLOTS  = sscrr_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_PAGES = sscrr_pkg::DEF_SLOT_PAGES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sscrr_pkg::ctrl_cmd_t                   cmd,
    output sscrr_pkg::ctrl_stat_t                  stat,
    input  logic [sscrr_pkg::ENTRY_W-1:0]          base_entry,
    input  logic [sscrr_pkg::HANDLE_W-1:0]         s_fb_handle,
    input  logic                                   s_has_backing,
    input  logic [sscrr_pkg::PAGES_W-1:0]          s_page_count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [sscrr_pkg::OFFSET_W-1:0]         m_surface_offset,
    output logic [sscrr_pkg::SLOTNUM_W-1:0]        m_slot_number,
    output logic [sscrr_pkg::STATUS_W-1:0]         m_status
);
    import sscrr_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PROD_W = SLOT_W + SLOT_PAGES_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // Captured request.
    logic [HANDLE_W-1:0] handle_reg;
    logic                backed_reg;
    logic [PAGES_W-1:0]  pages_reg;

    // Lookup outcome.
    logic [STATUS_W-1:0] kind_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                adv_reg;

    // Slot tables.
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [HANDLE_W-1:0]  owner_reg [NUM_SLOTS];
    logic [OFFSET_W-1:0]  surface_mem [NUM_SLOTS];
    logic [SLOT_W-1:0]    victim_reg;

    logic [OFFSET_W-1:0]  rd_surface_reg;
    logic [OFFSET_W-1:0]  offset_reg;

    logic                 out_valid_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic [SLOTNUM_W-1:0] out_slot_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic                 hit_any;
    logic [SLOT_W-1:0]    hit_idx;
    logic                 free_any;
    logic [SLOT_W-1:0]    free_idx;
    logic [STATUS_W-1:0]  kind_next;
    logic [SLOT_W-1:0]    slot_next;
    logic                 adv_next;
    logic [PROD_W-1:0]    slot_base;
    logic [ENTRY_W-1:0]   entry;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            handle_reg <= s_fb_handle;
            backed_reg <= s_has_backing;
            pages_reg  <= s_page_count;
        end
    end

    // Parallel tag compare; the lowest matching or lowest empty slot wins.
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && owner_reg[i] == handle_reg) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        kind_next = STAT_BOUND;
        slot_next = free_idx;
        adv_next  = 1'b0;
        if (!backed_reg || pages_reg == '0) begin
            kind_next = STAT_EMPTY;
        end else if (pages_reg > PAGES_W'(SLOT_PAGES)) begin
            kind_next = STAT_TOO_BIG;
        end else if (hit_any) begin
            kind_next = STAT_HIT;
            slot_next = hit_idx;
        end else if (!free_any) begin
            slot_next = victim_reg;
            adv_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            kind_reg <= kind_next;
            slot_reg <= slot_next;
            adv_reg  <= adv_next;
        end
    end

    // Offset wraps at 2^32, so only the low entry bits matter.
    assign slot_base = PROD_W'(slot_reg) * PROD_W'(SLOT_PAGES);
    assign entry     = base_entry + ENTRY_W'(slot_base);

    always_ff @(posedge aclk) begin
        rd_surface_reg <= surface_mem[slot_reg];
        offset_reg     <= {entry, {PAGE_SHIFT{1'b0}}};
        if (cmd.commit && kind_reg == STAT_BOUND) begin
            surface_mem[slot_reg] <= offset_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && kind_reg == STAT_BOUND) begin
            owner_reg[slot_reg] <= handle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            victim_reg <= '0;
        end else if (cmd.commit && kind_reg == STAT_BOUND) begin
            valid_reg[slot_reg] <= 1'b1;
            if (adv_reg) begin
                victim_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= kind_reg;
            case (kind_reg)
                STAT_HIT: begin
                    out_offset_reg <= rd_surface_reg;
                    out_slot_reg   <= SLOTNUM_W'(slot_reg);
                end
                STAT_BOUND: begin
                    out_offset_reg <= offset_reg;
                    out_slot_reg   <= SLOTNUM_W'(slot_reg);
                end
                default: begin
                    out_offset_reg <= '0;
                    out_slot_reg   <= '0;
                end
            endcase
        end
    end

    assign stat.out_space   = !out_valid_reg || m_ready;
    assign m_valid          = out_valid_reg;
    assign m_surface_offset = out_offset_reg;
    assign m_slot_number    = out_slot_reg;
    assign m_status         = out_status_reg;

endmodule

// ----- src/scanout_slot_cache_round_robin_core.sv -----
// Each bind transaction passes accept, tag compare, surface table read and commit in turn;
// the commit waits until the output register has room, and the result then shows on the m_ channel.
// The controller takes no new request until the current one has committed.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn, synchronous, active low) empties every slot and clears the victim
// pointer and base_entry; the surface table is not cleared and is read only for bound slots.
`include "scanout_slot_cache_round_robin_core_macros.svh"

module scanout_slot_cache_round_robin_core #(
    parameter int NUM_SLOTS  = sscrr_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_PAGES = sscrr_pkg::DEF_SLOT_PAGES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // APB-style configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [sscrr_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [sscrr_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [sscrr_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                   pready,
    // Bind request channel.
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [sscrr_pkg::HANDLE_W-1:0]         s_fb_handle,
    input  logic                                   s_has_backing,
    input  logic [sscrr_pkg::PAGES_W-1:0]          s_page_count,
    // Result channel.
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [sscrr_pkg::OFFSET_W-1:0]         m_surface_offset,
    output logic [sscrr_pkg::SLOTNUM_W-1:0]        m_slot_number,
    output logic [sscrr_pkg::STATUS_W-1:0]         m_status
);
    import sscrr_pkg::*;

    ctrl_cmd_t           cmd;
    ctrl_stat_t          stat;
    logic [ENTRY_W-1:0]  base_entry_reg;
    logic                cfg_write;

    // The port never stalls. Registers sit on 4-byte boundaries, so bit 2 picks
    // the register; only base_entry exists and any other index is ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_entry_reg <= '0;
        end else if (cfg_write && paddr[2] == REG_BASE_ENTRY) begin
            base_entry_reg <= pwdata[ENTRY_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BASE_ENTRY) ? CFG_DATA_W'(base_entry_reg) : '0;

    // The controller only issues commands; all tables and the result register
    // live in the datapath.
    sscrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sscrr_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .SLOT_PAGES (SLOT_PAGES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .base_entry       (base_entry_reg),
        .s_fb_handle      (s_fb_handle),
        .s_has_backing    (s_has_backing),
        .s_page_count     (s_page_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_surface_offset (m_surface_offset),
        .m_slot_number    (m_slot_number),
        .m_status         (m_status)
    );

    // Requests are handled one at a time, so an accepted transaction closes
    // the input until its commit.
    `SSCRR_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Error results always carry a zero offset and slot.
    `SSCRR_ASSERT_NOW(a_error_zero, aclk, aresetn,
        m_valid && (m_status == STAT_EMPTY || m_status == STAT_TOO_BIG),
        m_surface_offset == '0 && m_slot_number == '0)
    // A result is only loaded when the output register has room.
    `SSCRR_ASSERT_NOW(a_commit_room, aclk, aresetn, cmd.commit, !m_valid || m_ready)

endmodule
